// ===== sv/aeskx_pkg.sv =====
// ----------------------------------------------------------------------------
// aeskx_pkg: shared types and tables for the AES-128 key expansion
// Holds the S-box, the round constants and the controller-to-datapath command.
// ----------------------------------------------------------------------------
package aeskx_pkg;

  localparam int unsigned KeyWidth   = 128;
  localparam int unsigned HalfWidth  = 64;
  localparam int unsigned RoundWidth = 4;

  // Round key 0 is the cipher key itself; round key 10 is the last.
  localparam logic [RoundWidth-1:0] FirstRound = 4'd0;
  localparam logic [RoundWidth-1:0] LastRound  = 4'd10;

  // Forward S-box.
  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // Round constants, indexed by round; entry 0 never used.
  localparam logic [7:0] RCON [11] = '{
    8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  // Command from controller to datapath.
  typedef struct packed {
    logic                  load;    // capture the cipher key
    logic                  advance; // build the next round key
    logic [RoundWidth-1:0] round;   // round of the key being built
  } cmd_t;

  function automatic logic [7:0] rcon_of(input logic [RoundWidth-1:0] round);
    logic [7:0] rc;
    rc = 8'h00;
    if (round <= LastRound) begin
      rc = RCON[round];
    end
    return rc;
  endfunction

endpackage

// ===== sv/aeskx_ctrl.sv =====
// ----------------------------------------------------------------------------
// aeskx_ctrl: key expansion sequencer
// Counts rounds, issues load/advance commands and drives the handshake.
// ----------------------------------------------------------------------------
module aeskx_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  output logic                               out_valid,
  output logic [aeskx_pkg::RoundWidth-1:0]   out_round_number,
  output logic                               out_last_round,
  output aeskx_pkg::cmd_t                    cmd
);

  aeskx_pkg::state_t                   state_r, state_nxt;
  logic [aeskx_pkg::RoundWidth-1:0]    round_r, round_nxt;
  logic                                accept;
  logic                                at_last;

  assign at_last = (round_r == aeskx_pkg::LastRound);
  assign busy    = (state_r == aeskx_pkg::ST_RUN) && !at_last;
  assign accept  = start && !busy;

  always_comb begin
    state_nxt   = state_r;
    round_nxt   = round_r;
    cmd.load    = 1'b0;
    cmd.advance = 1'b0;
    cmd.round   = round_r + 4'd1;
    case (state_r)
      aeskx_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = aeskx_pkg::ST_RUN;
          round_nxt = aeskx_pkg::FirstRound;
          cmd.load  = 1'b1;
        end
      end
      aeskx_pkg::ST_RUN: begin
        if (!at_last) begin
          round_nxt   = round_r + 4'd1;
          cmd.advance = 1'b1;
        end else if (accept) begin
          round_nxt = aeskx_pkg::FirstRound;
          cmd.load  = 1'b1;
        end else begin
          state_nxt = aeskx_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = aeskx_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aeskx_pkg::ST_IDLE;
      round_r <= aeskx_pkg::FirstRound;
    end else begin
      state_r <= state_nxt;
      round_r <= round_nxt;
    end
  end

  assign out_valid        = (state_r == aeskx_pkg::ST_RUN);
  assign out_round_number = round_r;
  assign out_last_round   = out_valid && at_last;

  a_accept_starts_round0 : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid && (out_round_number == aeskx_pkg::FirstRound))
    else $error("accepted key not followed by round 0");

  a_rounds_in_order : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_round |=>
      out_valid && (out_round_number == $past(out_round_number) + 4'd1))
    else $error("round keys out of order");

  a_last_frees_port : assert property (@(posedge clk) disable iff (!rst_n)
    out_last_round |-> !busy)
    else $error("busy held on last round");

  a_busy_in_run : assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> out_valid && (out_round_number < aeskx_pkg::LastRound))
    else $error("busy outside an active schedule");

endmodule

// ===== sv/aeskx_datapath.sv =====
// ----------------------------------------------------------------------------
// aeskx_datapath: round key register and one-round schedule step
// Holds the current round key and derives the next one on command.
// ----------------------------------------------------------------------------
module aeskx_datapath (
  input  logic                                clk,
  input  aeskx_pkg::cmd_t                     cmd,
  input  logic [aeskx_pkg::HalfWidth-1:0]     in_key_high,
  input  logic [aeskx_pkg::HalfWidth-1:0]     in_key_low,
  output logic [aeskx_pkg::HalfWidth-1:0]     out_round_key_high,
  output logic [aeskx_pkg::HalfWidth-1:0]     out_round_key_low
);

  logic [aeskx_pkg::KeyWidth-1:0] key_r, key_nxt;
  logic [31:0] w0, w1, w2, w3;
  logic [31:0] rot, sub, n0, n1, n2, n3;

  assign w0 = key_r[127:96];
  assign w1 = key_r[95:64];
  assign w2 = key_r[63:32];
  assign w3 = key_r[31:0];

  // Rotate last word one byte left, substitute bytes, fold in round constant.
  assign rot = {w3[23:0], w3[31:24]};
  assign sub = {aeskx_pkg::SBOX[rot[31:24]] ^ aeskx_pkg::rcon_of(cmd.round),
                aeskx_pkg::SBOX[rot[23:16]],
                aeskx_pkg::SBOX[rot[15:8]],
                aeskx_pkg::SBOX[rot[7:0]]};

  assign n0 = w0 ^ sub;
  assign n1 = w1 ^ n0;
  assign n2 = w2 ^ n1;
  assign n3 = w3 ^ n2;

  always_comb begin
    key_nxt = key_r;
    if (cmd.load) begin
      key_nxt = {in_key_high, in_key_low};
    end else if (cmd.advance) begin
      key_nxt = {n0, n1, n2, n3};
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign out_round_key_high = key_r[127:64];
  assign out_round_key_low  = key_r[63:0];

endmodule

// ===== sv/aes128_key_expansion.sv =====
// ----------------------------------------------------------------------------
// aes128_key_expansion: AES-128 key schedule, eleven round keys per key
// Round key 0 appears in the cycle after start is taken, then one round
// key per cycle follows, up to round key 10.
// One key is expanded at a time, by the single shared round step.
// busy drops while round key 10 is shown, so a new key can start then.
// Reset (rst_n low, synchronous) returns the sequencer to idle; no word
// is emitted, and the key register itself has no reset.
// ----------------------------------------------------------------------------
module aes128_key_expansion (
  input  logic                               clk,
  input  logic                               rst_n,
  // command side: key taken when start is high and busy is low
  input  logic                               start,
  output logic                               busy,
  input  logic [aeskx_pkg::HalfWidth-1:0]    in_key_high,
  input  logic [aeskx_pkg::HalfWidth-1:0]    in_key_low,
  // result side: one word per cycle while out_valid is high, no back-pressure
  output logic                               out_valid,
  output logic [aeskx_pkg::HalfWidth-1:0]    out_round_key_high,
  output logic [aeskx_pkg::HalfWidth-1:0]    out_round_key_low,
  output logic [aeskx_pkg::RoundWidth-1:0]   out_round_number,
  output logic                               out_last_round
);

  // load / advance command from sequencer to key datapath
  aeskx_pkg::cmd_t cmd;

  // Sequencer: round counter and handshake. It loads the key on start,
  // then advances the datapath once per cycle until round 10 is shown.
  aeskx_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .out_valid        (out_valid),
    .out_round_number (out_round_number),
    .out_last_round   (out_last_round),
    .cmd              (cmd)
  );

  // Datapath: the round key register drives the result word directly,
  // so each round key is shown for exactly one cycle; the register changes only on a load or an advance.
  aeskx_datapath u_datapath (
    .clk                (clk),
    .cmd                (cmd),
    .in_key_high        (in_key_high),
    .in_key_low         (in_key_low),
    .out_round_key_high (out_round_key_high),
    .out_round_key_low  (out_round_key_low)
  );

endmodule

// ===== tb/sv/aes128_key_expansion_tb.sv =====
// ----------------------------------------------------------------------------
// aes128_key_expansion_tb: self-checking bench for the AES-128 key schedule
// Feeds cipher keys through the start/busy command port and checks all eleven
// round keys of each one against an in-bench schedule, in order, field by
// field. Starts idle at random, holds back at times until the block drains,
// and runs one long burst of keys with no random idling.
// ----------------------------------------------------------------------------
module aes128_key_expansion_tb;

  localparam int ROUND_KEYS  = 11;
  localparam int RANDOM_KEYS = 160;
  // Burst window (in accepted keys) with no random sender idling; drain holds still apply.
  localparam int BURST_FIRST = 60;
  localparam int BURST_LAST  = 110;

  // Forward S-box, one row of sixteen bytes per high nibble, byte 0 leftmost.
  localparam logic [127:0] SBOX_ROWS [16] = '{
    128'h637c777bf26b6fc53001672bfed7ab76,
    128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115,
    128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84,
    128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8,
    128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973,
    128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479,
    128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
    128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df,
    128'h8ca1890dbfe6426841992d0fb054bb16
  };

  typedef struct packed {
    logic [63:0] high;
    logic [63:0] low;
    logic        drain;   // hold this key back until every round key is out
  } cipher_key_t;

  typedef struct packed {
    logic [63:0] high;
    logic [63:0] low;
    logic [3:0]  num;
    logic        last;
  } round_key_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [63:0] in_key_high = '0;
  logic [63:0] in_key_low = '0;
  logic        out_valid;
  logic [63:0] out_round_key_high;
  logic [63:0] out_round_key_low;
  logic [3:0]  out_round_number;
  logic        out_last_round;

  cipher_key_t key_q[$];          // keys waiting to be sent
  round_key_t  round_key_q[$];    // every expected round key, in order
  int          expected_cnt = 0;  // round keys predicted so far (updated by NBA)
  int          checked_cnt = 0;   // round keys received so far (updated by NBA)
  int          keys_taken = 0;
  int          errors = 0;

  aes128_key_expansion dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_key_high        (in_key_high),
    .in_key_low         (in_key_low),
    .out_valid          (out_valid),
    .out_round_key_high (out_round_key_high),
    .out_round_key_low  (out_round_key_low),
    .out_round_number   (out_round_number),
    .out_last_round     (out_last_round)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Key schedule predictor
  // --------------------------------------------------------------------------
  function automatic logic [7:0] sbox_byte(input logic [7:0] v);
    return SBOX_ROWS[v[7:4]][(15 - v[3:0]) * 8 +: 8];
  endfunction

  // Rotate left by one byte, then substitute every byte.
  function automatic logic [31:0] rot_sub_word(input logic [31:0] w);
    logic [31:0] r;
    logic [31:0] s;
    r = {w[23:0], w[31:24]};
    for (int b = 0; b < 4; b++) begin
      s[b * 8 +: 8] = sbox_byte(r[b * 8 +: 8]);
    end
    return s;
  endfunction

  // Append the eleven round keys of one cipher key to the expected store.
  function automatic void schedule_round_keys(input logic [63:0] key_high,
                                              input logic [63:0] key_low);
    logic [31:0] w [4];
    logic [7:0]  rcon;
    round_key_t  rk;
    w[0] = key_high[63:32];
    w[1] = key_high[31:0];
    w[2] = key_low[63:32];
    w[3] = key_low[31:0];
    rcon = 8'h01;
    for (int r = 0; r < ROUND_KEYS; r++) begin
      if (r > 0) begin
        w[0] = w[0] ^ rot_sub_word(w[3]) ^ {rcon, 24'h000000};
        w[1] = w[1] ^ w[0];
        w[2] = w[2] ^ w[1];
        w[3] = w[3] ^ w[2];
        // advance the round constant: multiply by x in GF(2^8)
        rcon = {rcon[6:0], 1'b0} ^ (rcon[7] ? 8'h1b : 8'h00);
      end
      rk.high = {w[0], w[1]};
      rk.low  = {w[2], w[3]};
      rk.num  = 4'(r);
      rk.last = (r == ROUND_KEYS - 1);
      round_key_q.push_back(rk);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver: present one key word at a time, hold start while busy.
  // The key on the ports is taken at an edge where start is high and busy low.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive
    logic        offer;
    logic        taken;
    logic        may_idle;
    cipher_key_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      offer = start;
      taken = start && !busy;
      if (taken) begin
        // predict from the word that was on the ports before this edge
        schedule_round_keys(in_key_high, in_key_low);
        expected_cnt <= expected_cnt + ROUND_KEYS;
        keys_taken++;
        offer = 1'b0;
      end
      if (!offer && key_q.size() != 0) begin
        nxt = key_q[0];
        may_idle = (keys_taken < BURST_FIRST) || (keys_taken >= BURST_LAST);
        if (nxt.drain && (taken || expected_cnt != checked_cnt)) begin
          // hold back: wait for the block to drain every pending round key
        end else if (may_idle && $urandom_range(99) < 17) begin
          // idle this cycle
        end else begin
          void'(key_q.pop_front());
          in_key_high <= nxt.high;
          in_key_low  <= nxt.low;
          offer = 1'b1;
        end
      end
      start <= offer;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every strobed word must match the oldest expected round key.
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    round_key_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (checked_cnt >= expected_cnt) begin
        $display("%0t: unexpected round key: expected none, actual %h_%h round %0d",
                 $time, out_round_key_high, out_round_key_low, out_round_number);
        errors++;
      end else begin
        want = round_key_q[checked_cnt];
        check_field("round_key_high", want.high, out_round_key_high);
        check_field("round_key_low", want.low, out_round_key_low);
        check_field("round_number", 64'(want.num), 64'(out_round_number));
        check_field("last_round", 64'(want.last), 64'(out_last_round));
        checked_cnt <= checked_cnt + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of test
  // --------------------------------------------------------------------------
  function automatic void queue_key(input logic [63:0] high, input logic [63:0] low,
                                    input logic drain);
    cipher_key_t k;
    k.high  = high;
    k.low   = low;
    k.drain = drain;
    key_q.push_back(k);
  endfunction

  function automatic logic [63:0] rand_half();
    return {$urandom(), $urandom()};
  endfunction

  initial begin : stimulus
    logic [63:0] h;
    logic [63:0] l;
    logic [7:0]  fill;
    // Directed: extremes, the standard test keys, one-hot and repeated bytes.
    queue_key(64'h0, 64'h0, 1'b0);
    queue_key('1, '1, 1'b0);
    queue_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 1'b0);
    queue_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f, 1'b1);
    queue_key(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0);
    queue_key(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0);
    queue_key(64'h8000000000000000, 64'h0000000000000001, 1'b0);
    queue_key(64'h0, 64'h0000000080000000, 1'b0);
    queue_key(64'hffffffffffffffff, 64'h0, 1'b1);
    queue_key(64'h0, 64'hffffffffffffffff, 1'b0);
    queue_key(64'h0f0e0d0c0b0a0908, 64'h0706050403020100, 1'b0);
    queue_key(64'h6363636363636363, 64'h6363636363636363, 1'b0);
    // Random: mostly uniform keys, some repeated-byte patterns, a few drains.
    for (int i = 0; i < RANDOM_KEYS; i++) begin
      if ($urandom_range(9) < 2) begin
        fill = 8'($urandom());
        h = {8{fill}} ^ (64'(1) << $urandom_range(63));
        l = {8{fill}};
      end else begin
        h = rand_half();
        l = rand_half();
      end
      queue_key(h, l, (i % 37) == 36);
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every key to be taken and every round key to come back.
    @(negedge clk);
    while (key_q.size() != 0 || start || checked_cnt != expected_cnt) begin
      @(negedge clk);
    end
    // Let the clock run on for three more schedules' worth of time to catch stray words.
    repeat (3 * ROUND_KEYS) @(negedge clk);

    if (errors == 0 && checked_cnt == expected_cnt) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard limit: far beyond the slowest correct run.
  initial begin : watchdog
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
